// ===== hw/rtl/ssed_pkg.sv =====
// ssed_pkg: shared types and constants of the scale-space extremum detector
// no dependencies; imported by every module of the block except ssed_ram
package ssed_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COORD_BITS     = 10;
    localparam int SIZE_BITS      = 11;
    localparam int THRESH_BITS    = 15;
    localparam int CFG_DATA_BITS  = 15;
    localparam int CFG_INDEX_BITS = 2;
    localparam int OUTQ_DEPTH     = 4;
    localparam int OUTQ_CNT_BITS  = $clog2(OUTQ_DEPTH + 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH        = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CONTRAST_THRESHOLD = 2'd2;

    localparam logic [SIZE_BITS-1:0]   IMAGE_WIDTH_RESET        = 11'd640;
    localparam logic [SIZE_BITS-1:0]   IMAGE_HEIGHT_RESET       = 11'd480;
    localparam logic [THRESH_BITS-1:0] CONTRAST_THRESHOLD_RESET = 15'd0;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // three scale layers of one pixel
    typedef struct packed {
        sample_t lower;
        sample_t middle;
        sample_t upper;
    } triple_t;

    // one line store entry: the two rows above the incoming pixel
    typedef struct packed {
        triple_t older;
        triple_t newer;
    } line_entry_t;

    typedef struct packed {
        logic    frame_start;
        sample_t lower_sample;
        sample_t middle_sample;
        sample_t upper_sample;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] center_row;
        logic [COORD_BITS-1:0] center_col;
        sample_t               center_value;
        logic                  is_minimum;
    } out_item_t;

    // new window column handed from the line store stage to the window
    typedef struct packed {
        logic                  valid;
        logic                  border_ok;
        logic [COORD_BITS-1:0] center_row;
        logic [COORD_BITS-1:0] center_col;
        triple_t               above2;
        triple_t               above1;
        triple_t               cur;
    } column_t;

    // window compare status and result
    typedef struct packed {
        logic      busy;
        logic      push;
        out_item_t item;
    } result_t;

endpackage

// ===== hw/rtl/ssed_ram.sv =====
// ssed_ram: generic single-clock ram, one write port and one registered read port
// depends on nothing; used for the line store
module ssed_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ssed_window.sv =====
// ssed_window: 3x3 window of three layers and the 26-neighbour extremum test
// depends on ssed_pkg
module ssed_window
    import ssed_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  column_t                column,
    input  logic [THRESH_BITS-1:0] contrast_threshold,
    output result_t                result
);

    triple_t               win_reg [3][3];
    logic                  cmp_valid_reg;
    logic [COORD_BITS-1:0] cmp_row_reg;
    logic [COORD_BITS-1:0] cmp_col_reg;

    sample_t              center;
    logic [SAMPLE_BITS:0] magnitude;
    logic                 positive;
    logic                 fail;

    // row 0 is the oldest row, column 2 the newest pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            if (column.valid)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= column.above2;
                win_reg[1][2] <= column.above1;
                win_reg[2][2] <= column.cur;
            end
            cmp_valid_reg <= column.valid && column.border_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (column.valid)
        begin
            cmp_row_reg <= column.center_row;
            cmp_col_reg <= column.center_col;
        end
    end

    always_comb
    begin
        center    = win_reg[1][1].middle;
        magnitude = center[SAMPLE_BITS-1] ? -{center[SAMPLE_BITS-1], center}
                                          : {1'b0, center};
        positive  = !center[SAMPLE_BITS-1] && (center != '0);
        fail      = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (positive)
                begin
                    if (win_reg[r][c].lower > center || win_reg[r][c].upper > center)
                    begin
                        fail = 1'b1;
                    end
                    if ((r != 1 || c != 1) && win_reg[r][c].middle > center)
                    begin
                        fail = 1'b1;
                    end
                end
                else
                begin
                    if (win_reg[r][c].lower < center || win_reg[r][c].upper < center)
                    begin
                        fail = 1'b1;
                    end
                    if ((r != 1 || c != 1) && win_reg[r][c].middle < center)
                    begin
                        fail = 1'b1;
                    end
                end
            end
        end
    end

    assign result.busy = cmp_valid_reg;
    assign result.push = cmp_valid_reg && !fail &&
                         (magnitude > (SAMPLE_BITS + 1)'(contrast_threshold));
    assign result.item.center_row   = cmp_row_reg;
    assign result.item.center_col   = cmp_col_reg;
    assign result.item.center_value = center;
    assign result.item.is_minimum   = center[SAMPLE_BITS-1];

endmodule

// ===== hw/rtl/ssed_fifo.sv =====
// ssed_fifo: small output queue that decouples the compare from a stalling receiver
// depends on ssed_pkg
module ssed_fifo
    import ssed_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  out_item_t                push_item,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_item_t                out_data,
    output logic [OUTQ_CNT_BITS-1:0] count
);

    localparam int PTR_BITS = $clog2(OUTQ_DEPTH);

    out_item_t                q_reg [OUTQ_DEPTH];
    logic [PTR_BITS-1:0]      wr_ptr_reg;
    logic [PTR_BITS-1:0]      rd_ptr_reg;
    logic [OUTQ_CNT_BITS-1:0] count_reg;
    logic                     pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = q_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + OUTQ_CNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - OUTQ_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/scale_space_extremum_detector.sv =====
// scale_space_extremum_detector: 3x3x3 difference-of-gaussian peak search, top level
// depends on ssed_pkg, ssed_ram, ssed_window, ssed_fifo
//
// usage: pixels enter in raster order on the in channel (in_valid, in_stall, in_data),
// each carrying the lower, middle and upper layer samples; frame_start marks row 0,
// column 0. a candidate peak leaves on the out channel (out_valid, out_stall, out_data)
// with the row and column of the window centre, one row and one column behind the
// incoming pixel. a pixel yields zero or one result.
// throughput: one pixel per cycle when not stalled; the line store is read and written
// back once per pixel, with forwarding when consecutive pixels hit the same column.
// pipeline: a result passes the line store read, the window update and the compare
// into the queue before it shows on out_valid.
// stall: a four-entry output queue absorbs receiver stalls; in_stall rises only when
// the queue plus the pixels still in the pipe could fill it.
// config: cfg_we, cfg_index, cfg_data write image width, image height and contrast
// threshold; write only while the block is idle.
// reset: position counters and the window clear, the output queue empties; the line
// store is not cleared and is filled by the first rows of a frame.
module scale_space_extremum_detector
    import ssed_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int BORDER     = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_item_t                 out_data,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int MAXCR = (CW > RW) ? CW : RW;
    localparam int PW    = ((MAXCR > SIZE_BITS) ? MAXCR : SIZE_BITS) + 2;
    localparam int EW    = $bits(line_entry_t);

    logic [SIZE_BITS-1:0]   image_width_reg;
    logic [SIZE_BITS-1:0]   image_height_reg;
    logic [THRESH_BITS-1:0] contrast_threshold_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic [PW-1:0] w_eff;
    logic [PW-1:0] h_eff;
    logic [PW-1:0] c0, r0, c1, r1, r2, cn, rn;
    logic [PW-1:0] col_next;
    logic [PW-1:0] row_next;
    logic          border_ok;
    logic          accept;

    logic                  s1_valid_reg;
    logic                  s1_border_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [COORD_BITS-1:0] s1_center_row_reg;
    logic [COORD_BITS-1:0] s1_center_col_reg;
    triple_t               s1_cur_reg;

    logic        fwd_hit_reg;
    line_entry_t fwd_entry_reg;
    logic [EW-1:0] ram_rd_data;
    line_entry_t rd_entry;
    line_entry_t wr_entry;

    column_t                  column;
    result_t                  result;
    logic [OUTQ_CNT_BITS-1:0] q_count;
    logic [OUTQ_CNT_BITS-1:0] occupancy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg        <= IMAGE_WIDTH_RESET;
            image_height_reg       <= IMAGE_HEIGHT_RESET;
            contrast_threshold_reg <= CONTRAST_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:        image_width_reg <= cfg_data[SIZE_BITS-1:0];
                REG_IMAGE_HEIGHT:       image_height_reg <= cfg_data[SIZE_BITS-1:0];
                REG_CONTRAST_THRESHOLD: contrast_threshold_reg <= cfg_data[THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes clamped to [1, max]
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = PW'(1);
        else if (PW'(image_width_reg) > PW'(MAX_WIDTH))
            w_eff = PW'(MAX_WIDTH);
        else
            w_eff = PW'(image_width_reg);

        if (image_height_reg == '0)
            h_eff = PW'(1);
        else if (PW'(image_height_reg) > PW'(MAX_HEIGHT))
            h_eff = PW'(MAX_HEIGHT);
        else
            h_eff = PW'(image_height_reg);
    end

    // position of the incoming pixel and of the next one
    always_comb
    begin
        c0 = in_data.frame_start ? '0 : PW'(col_reg);
        r0 = in_data.frame_start ? '0 : PW'(row_reg);
        // stale position after a size change wraps before use
        if (c0 >= w_eff)
        begin
            c1 = '0;
            r1 = r0 + PW'(1);
        end
        else
        begin
            c1 = c0;
            r1 = r0;
        end
        r2 = (r1 >= h_eff) ? '0 : r1;

        cn = c1 + PW'(1);
        rn = r2 + PW'(1);
        if (cn >= w_eff)
        begin
            col_next = '0;
            row_next = (rn >= h_eff) ? '0 : rn;
        end
        else
        begin
            col_next = cn;
            row_next = r2;
        end

        border_ok = (r2 >= PW'(BORDER + 1)) && ((r2 + PW'(BORDER)) <= h_eff) &&
                    (c1 >= PW'(BORDER + 1)) && ((c1 + PW'(BORDER)) <= w_eff);
    end

    assign occupancy = q_count + OUTQ_CNT_BITS'(s1_valid_reg) + OUTQ_CNT_BITS'(result.busy);
    assign in_stall  = (occupancy >= OUTQ_CNT_BITS'(OUTQ_DEPTH));
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next[CW-1:0];
                row_reg <= row_next[RW-1:0];
            end
            s1_valid_reg <= accept;
            // the ram returns old data when read and written at one address in a cycle
            fwd_hit_reg  <= accept && s1_valid_reg && (s1_col_reg == c1[CW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg        <= c1[CW-1:0];
            s1_border_reg     <= border_ok;
            s1_center_row_reg <= COORD_BITS'(r2 - PW'(1));
            s1_center_col_reg <= COORD_BITS'(c1 - PW'(1));
            s1_cur_reg.lower  <= in_data.lower_sample;
            s1_cur_reg.middle <= in_data.middle_sample;
            s1_cur_reg.upper  <= in_data.upper_sample;
        end
        fwd_entry_reg <= wr_entry;
    end

    assign rd_entry       = fwd_hit_reg ? fwd_entry_reg : line_entry_t'(ram_rd_data);
    assign wr_entry.older = rd_entry.newer;
    assign wr_entry.newer = s1_cur_reg;

    ssed_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (EW'(wr_entry)),
        .rd_en   (accept),
        .rd_addr (c1[CW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign column.valid      = s1_valid_reg;
    assign column.border_ok  = s1_border_reg;
    assign column.center_row = s1_center_row_reg;
    assign column.center_col = s1_center_col_reg;
    assign column.above2     = rd_entry.older;
    assign column.above1     = rd_entry.newer;
    assign column.cur        = s1_cur_reg;

    ssed_window u_window (
        .clk                (clk),
        .rst_n              (rst_n),
        .column             (column),
        .contrast_threshold (contrast_threshold_reg),
        .result             (result)
    );

    ssed_fifo u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result.push),
        .push_item (result.item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .count     (q_count)
    );

endmodule

// ===== hw/rtl/ssed_checker.sv =====
// ssed_checker: port-level assertions for the extremum detector, bound to the top level
// depends on ssed_pkg and scale_space_extremum_detector
module ssed_checker
    import ssed_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("out_data changed while stalled");

    // an empty output queue never blocks the input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("in_stall high with no result pending");

    // a result into an empty queue follows an earlier pixel transfer
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
        else $error("result without a matching pixel transfer");

    // minimum flag follows the sign of a nonzero centre
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.center_value != '0) &&
                      (out_data.is_minimum == out_data.center_value[SAMPLE_BITS-1]))
        else $error("is_minimum disagrees with center_value");

endmodule

bind scale_space_extremum_detector ssed_checker u_ssed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
